@@ rtl/core/mta_pkg.sv @@
// Package for the mouse to analog stick converter: constants, codes, the
// controller/datapath command and status structs and a rounding helper.
// No dependencies.
package mta_pkg;

   localparam int PAD_COUNT = 4;
   localparam int PAD_W     = $clog2(PAD_COUNT);

   localparam int AIM_LIMIT   = 13056;
   localparam int DEADZONE    = 128;
   localparam int FOV_MIN_Q8  = 768;
   localparam int FOV_RECIP   = 34953;   // ceil(2^21 / 60), exact for 16-bit fov
   localparam int FOV_SHIFT   = 21;
   localparam int FOV_F_MIN   = 3;
   localparam int ONE_Q8      = 256;
   localparam int CURVE_K     = 132651;  // 51^3; 13056^3 = CURVE_K << 24
   localparam int CURVE_SHIFT = 24;
   localparam int SQ_STEPS    = 28;      // root bits of a 56-bit radicand
   localparam int SQ_CNT_W    = $clog2(SQ_STEPS);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ENABLE   = 3'd0,
      REG_SCALE    = 3'd1,
      REG_LIMIT    = 3'd2,
      REG_STEP_X   = 3'd3,
      REG_STEP_Y   = 3'd4,
      REG_ATTACK   = 3'd5,
      REG_A_DECAY  = 3'd6,
      REG_R_DECAY  = 3'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL1,
      OP_MUL2,
      OP_F1,
      OP_F2,
      OP_F3,
      OP_F4,
      OP_A1,
      OP_SQRT,
      OP_SQ2LOAD,
      OP_AWB,
      OP_OUT
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_F1,
      ST_F2,
      ST_F3,
      ST_F4,
      ST_A1,
      ST_SQ1,
      ST_MID,
      ST_SQ2,
      ST_AWB,
      ST_OUT
   } state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic blank;   // item gives a centered, undriven stick
      logic aim;     // item runs the aim path
   } dp_status_type;

   // Shift right by s with round to nearest, ties away from zero.
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int unsigned s);
      logic signed [63:0] half;
      half = 64'sd1 <<< (s - 1);
      return (v + half - (v[63] ? 64'sd1 : 64'sd0)) >>> s;
   endfunction

endpackage

@@ rtl/core/mta_chan_if.sv @@
// Valid/ready channel interfaces for request and response transactions.
// No dependencies.
interface mta_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         pad_index;
   logic signed [19:0] delta_x;
   logic signed [19:0] delta_y;
   logic [15:0]        view_fov;
   logic               camera_active;
   logic               aim_active;

   modport source(output valid, pad_index, delta_x, delta_y, view_fov, camera_active,
                  aim_active, input ready);
   modport sink(input valid, pad_index, delta_x, delta_y, view_fov, camera_active,
                aim_active, output ready);
endinterface

interface mta_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] stick_x;
   logic [7:0] stick_y;
   logic       stick_valid;

   modport source(output valid, stick_x, stick_y, stick_valid, input ready);
   modport sink(input valid, stick_x, stick_y, stick_valid, output ready);
endinterface

@@ rtl/core/mouse_to_analog_stick_core.sv @@
// Mouse to analog stick converter, top level: four pads of stick state.
// Depends on mta_pkg, mta_chan_if, mta_ctrl and mta_datapath.
//
// One transaction at a time. A request for a pad in free-look mode runs
// the multiply and filter states (MUL1, MUL2, F1 to F4) before the output
// state; one that clears the pad (mouse mode off or camera inactive) goes
// from MUL1 straight to the output state. Aim mode runs the fourth-root
// curve instead of the filter: two 28-step bit-serial square root passes,
// both axes in parallel. A finished result sits in the output register and
// the block goes back to accepting requests as soon as it is loaded; while
// the previous result is still waiting there, the load is held. The user
// must write configuration through csr_write_en/csr_index/csr_wdata only
// while no transaction is in flight, unenforced by the block; no read-back.
module mouse_to_analog_stick_core
   import mta_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   mta_req_if.sink               req_chan,
   mta_rsp_if.source             rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   mta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mta_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_pad_index     (req_chan.pad_index),
      .req_delta_x       (req_chan.delta_x),
      .req_delta_y       (req_chan.delta_y),
      .req_view_fov      (req_chan.view_fov),
      .req_camera_active (req_chan.camera_active),
      .req_aim_active    (req_chan.aim_active),
      .cmd               (cmd),
      .status            (status),
      .rsp_stick_x       (rsp_chan.stick_x),
      .rsp_stick_y       (rsp_chan.stick_y),
      .rsp_stick_valid   (rsp_chan.stick_valid)
   );

endmodule

@@ rtl/core/mta_datapath.sv @@
// Datapath: configuration registers, per-pad state, multipliers, clamps and
// a two-lane bit-serial square root. Driven by mta_ctrl; depends on mta_pkg.
module mta_datapath
   import mta_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [1:0]            req_pad_index,
   input  logic signed [19:0]    req_delta_x,
   input  logic signed [19:0]    req_delta_y,
   input  logic [15:0]           req_view_fov,
   input  logic                  req_camera_active,
   input  logic                  req_aim_active,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic [7:0]            rsp_stick_x,
   output logic [7:0]            rsp_stick_y,
   output logic                  rsp_stick_valid
);

   // configuration
   logic        en_ff;
   logic [15:0] scale_ff;
   logic [14:0] limit_ff, step_x_ff, step_y_ff;
   logic [8:0]  attack_ff, a_decay_ff, r_decay_ff;

   // per-pad state
   logic signed [15:0] raw_mem_ff [PAD_COUNT][2];
   logic signed [15:0] pos_mem_ff [PAD_COUNT][2];
   logic signed [15:0] aim_mem_ff [PAD_COUNT][2];
   logic               latched_ff [PAD_COUNT];

   // item working registers
   logic [PAD_W-1:0]   pad_ff;
   logic               blank_ff, aim_ff;
   logic [8:0]         f_ff;
   logic signed [20:0] d_ff       [2];
   logic signed [15:0] raw_w_ff   [2], raw_w_in [2];
   logic signed [15:0] pos_w_ff   [2], pos_w_in [2];
   logic signed [15:0] aim_w_ff   [2], aim_w_in [2];
   logic signed [30:0] prod1_ff   [2], prod1_in [2];
   logic signed [47:0] prod2_ff   [2], prod2_in [2];
   logic signed [26:0] mul_ff     [2], mul_in   [2];
   logic signed [31:0] tgt_ff     [2], tgt_in   [2];
   logic [55:0]        rad_ff     [2], rad_in   [2];
   logic [29:0]        rem_ff     [2], rem_in   [2];
   logic [27:0]        root_ff    [2], root_in  [2];
   logic [7:0]         byte_in    [2];
   logic [7:0]         stick_x_ff, stick_y_ff;
   logic               stick_valid_ff;

   logic [PAD_W-1:0] pad_idx;
   logic             pad_ok, mode_off, mode_change;
   logic [31:0]      fov_prod;
   logic [10:0]      fov_q;
   logic [8:0]       f_in;

   assign pad_idx     = req_pad_index[PAD_W-1:0];
   assign pad_ok      = 32'(req_pad_index) < 32'(PAD_COUNT);
   assign mode_off    = !en_ff || !req_camera_active;
   assign mode_change = req_aim_active != latched_ff[pad_idx];
   assign fov_prod    = 32'(req_view_fov) * 32'(FOV_RECIP);
   assign fov_q       = fov_prod[31:FOV_SHIFT];

   always_comb begin
      if (32'(req_view_fov) <= 32'(FOV_MIN_Q8)) begin
         f_in = 9'(ONE_Q8);
      end else if (32'(fov_q) < 32'(FOV_F_MIN)) begin
         f_in = 9'(FOV_F_MIN);
      end else if (32'(fov_q) > 32'(ONE_Q8)) begin
         f_in = 9'(ONE_Q8);
      end else begin
         f_in = fov_q[8:0];
      end
   end

   // per-axis lanes
   always_comb begin
      logic signed [15:0] step;
      logic signed [63:0] r64, s64, v64, c64;
      logic signed [16:0] diff;
      logic [13:0]        mag;
      logic [29:0]        rem2, trial;
      logic [16:0]        bsum;
      for (int a = 0; a < 2; a++) begin
         raw_w_in[a] = raw_w_ff[a];
         pos_w_in[a] = pos_w_ff[a];
         aim_w_in[a] = aim_w_ff[a];
         prod1_in[a] = prod1_ff[a];
         prod2_in[a] = prod2_ff[a];
         mul_in[a]   = mul_ff[a];
         tgt_in[a]   = tgt_ff[a];
         rad_in[a]   = rad_ff[a];
         rem_in[a]   = rem_ff[a];
         root_in[a]  = root_ff[a];
         step = {1'b0, (a == 0) ? step_x_ff : step_y_ff};
         r64 = '0; s64 = '0; v64 = '0; c64 = '0; diff = '0; mag = '0;
         rem2 = {rem_ff[a][27:0], rad_ff[a][55:54]};
         trial = {root_ff[a], 2'b01};
         bsum = {1'b0, ~pos_w_ff[a][15], pos_w_ff[a][14:0]} + 17'd128;
         byte_in[a] = bsum[16] ? 8'd255 : bsum[15:8];
         case (cmd.op)
            OP_MUL1: begin
               prod1_in[a] = d_ff[a] * $signed({1'b0, f_ff});
            end
            OP_MUL2: begin
               prod2_in[a] = prod1_ff[a] * $signed({1'b0, scale_ff});
               r64 = rnd_shift(64'(prod1_ff[a]), 8);
               s64 = 64'(aim_w_ff[a]) + r64;
               if (s64 > 64'sd13056) begin
                  s64 = 64'(AIM_LIMIT);
               end else if (s64 < -64'sd13056) begin
                  s64 = -64'(AIM_LIMIT);
               end
               if (aim_ff) begin
                  aim_w_in[a] = s64[15:0];
               end
            end
            OP_F1: begin
               mul_in[a] = 27'(raw_w_ff[a] * $signed({1'b0, a_decay_ff}));
               r64 = rnd_shift(64'(prod2_ff[a]), 16);
               tgt_in[a] = r64[31:0];
            end
            OP_F2: begin
               s64 = rnd_shift(64'(mul_ff[a]), 8) + 64'(tgt_ff[a]);
               if (s64 > $signed(64'(limit_ff))) begin
                  s64 = 64'(limit_ff);
               end else if (s64 < -$signed(64'(limit_ff))) begin
                  s64 = -$signed(64'(limit_ff));
               end
               raw_w_in[a] = s64[15:0];
            end
            OP_F3: begin
               diff = 17'(raw_w_ff[a]) - 17'(pos_w_ff[a]);
               if (raw_w_ff[a] > -16'sd128 && raw_w_ff[a] < 16'sd128) begin
                  mul_in[a] = 27'(pos_w_ff[a] * $signed({1'b0, r_decay_ff}));
               end else begin
                  mul_in[a] = 27'(diff * $signed({1'b0, attack_ff}));
               end
            end
            OP_F4: begin
               v64 = rnd_shift(64'(mul_ff[a]), 8);
               if (raw_w_ff[a] > -16'sd128 && raw_w_ff[a] < 16'sd128) begin
                  s64 = v64;
                  if (v64 > -64'sd128 && v64 < 64'sd128) begin
                     s64 = '0;
                  end
               end else begin
                  c64 = v64;
                  if (c64 > 64'(step)) begin
                     c64 = 64'(step);
                  end else if (c64 < -64'(step)) begin
                     c64 = -64'(step);
                  end
                  s64 = 64'(pos_w_ff[a]) + c64;
               end
               // decay above unity can overshoot too
               if (s64 > 64'sd32767) begin
                  s64 = 64'sd32767;
               end else if (s64 < -64'sd32768) begin
                  s64 = -64'sd32768;
               end
               pos_w_in[a] = s64[15:0];
            end
            OP_A1: begin
               mag = aim_w_ff[a][15] ? 14'(-aim_w_ff[a]) : aim_w_ff[a][13:0];
               rad_in[a] = 56'(32'(mag) * 32'(CURVE_K)) << CURVE_SHIFT;
               rem_in[a] = '0;
               root_in[a] = '0;
            end
            OP_SQRT: begin
               rad_in[a] = {rad_ff[a][53:0], 2'b00};
               if (rem2 >= trial) begin
                  rem_in[a]  = rem2 - trial;
                  root_in[a] = {root_ff[a][26:0], 1'b1};
               end else begin
                  rem_in[a]  = rem2;
                  root_in[a] = {root_ff[a][26:0], 1'b0};
               end
            end
            OP_SQ2LOAD: begin
               rad_in[a] = {28'd0, root_ff[a]};
               rem_in[a] = '0;
               root_in[a] = '0;
            end
            OP_AWB: begin
               pos_w_in[a] = aim_w_ff[a][15] ? -$signed(root_ff[a][15:0])
                                             : $signed(root_ff[a][15:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff      <= 1'b1;
         scale_ff   <= 16'd2560;
         limit_ff   <= 15'd14336;
         step_x_ff  <= 15'd3072;
         step_y_ff  <= 15'd2816;
         attack_ff  <= 9'd38;
         a_decay_ff <= 9'd210;
         r_decay_ff <= 9'd141;
         for (int p = 0; p < PAD_COUNT; p++) begin
            latched_ff[p] <= 1'b0;
            for (int a = 0; a < 2; a++) begin
               raw_mem_ff[p][a] <= '0;
               pos_mem_ff[p][a] <= '0;
               aim_mem_ff[p][a] <= '0;
            end
         end
         blank_ff       <= 1'b1;
         aim_ff         <= 1'b0;
         stick_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (reg_index_type'(csr_index))
               REG_ENABLE:  en_ff      <= csr_wdata[0];
               REG_SCALE:   scale_ff   <= csr_wdata;
               REG_LIMIT:   limit_ff   <= csr_wdata[14:0];
               REG_STEP_X:  step_x_ff  <= csr_wdata[14:0];
               REG_STEP_Y:  step_y_ff  <= csr_wdata[14:0];
               REG_ATTACK:  attack_ff  <= csr_wdata[8:0];
               REG_A_DECAY: a_decay_ff <= csr_wdata[8:0];
               REG_R_DECAY: r_decay_ff <= csr_wdata[8:0];
               default: begin
               end
            endcase
         end
         if (cmd.op == OP_LOAD) begin
            blank_ff <= mode_off || !pad_ok;
            aim_ff   <= req_aim_active;
            if (pad_ok) begin
               latched_ff[pad_idx] <= mode_off ? 1'b0 : req_aim_active;
               if (mode_off) begin
                  for (int a = 0; a < 2; a++) begin
                     raw_mem_ff[pad_idx][a] <= '0;
                     pos_mem_ff[pad_idx][a] <= '0;
                     aim_mem_ff[pad_idx][a] <= '0;
                  end
               end
            end
         end
         if (cmd.op == OP_OUT) begin
            stick_valid_ff <= !blank_ff;
            if (!blank_ff) begin
               for (int a = 0; a < 2; a++) begin
                  raw_mem_ff[pad_ff][a] <= raw_w_ff[a];
                  pos_mem_ff[pad_ff][a] <= pos_w_ff[a];
                  aim_mem_ff[pad_ff][a] <= aim_w_ff[a];
               end
            end
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         pad_ff  <= pad_idx;
         f_ff    <= f_in;
         d_ff[0] <= 21'(req_delta_x);
         d_ff[1] <= -21'(req_delta_y);
         for (int a = 0; a < 2; a++) begin
            if (mode_off || mode_change) begin
               raw_w_ff[a] <= '0;
               pos_w_ff[a] <= '0;
               aim_w_ff[a] <= '0;
            end else begin
               raw_w_ff[a] <= raw_mem_ff[pad_idx][a];
               pos_w_ff[a] <= pos_mem_ff[pad_idx][a];
               aim_w_ff[a] <= aim_mem_ff[pad_idx][a];
            end
         end
      end else begin
         for (int a = 0; a < 2; a++) begin
            raw_w_ff[a] <= raw_w_in[a];
            pos_w_ff[a] <= pos_w_in[a];
            aim_w_ff[a] <= aim_w_in[a];
         end
      end
      for (int a = 0; a < 2; a++) begin
         prod1_ff[a] <= prod1_in[a];
         prod2_ff[a] <= prod2_in[a];
         mul_ff[a]   <= mul_in[a];
         tgt_ff[a]   <= tgt_in[a];
         rad_ff[a]   <= rad_in[a];
         rem_ff[a]   <= rem_in[a];
         root_ff[a]  <= root_in[a];
      end
      if (cmd.op == OP_OUT) begin
         stick_x_ff <= blank_ff ? 8'd128 : byte_in[0];
         stick_y_ff <= blank_ff ? 8'd128 : byte_in[1];
      end
   end

   assign status.blank    = blank_ff;
   assign status.aim      = aim_ff;
   assign rsp_stick_x     = stick_x_ff;
   assign rsp_stick_y     = stick_y_ff;
   assign rsp_stick_valid = stick_valid_ff;

endmodule

@@ rtl/core/mta_ctrl.sv @@
// Controller: sequences one transaction through the datapath and owns the
// request ready and response valid. Depends on mta_pkg.
module mta_ctrl
   import mta_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type           state_ff, state_in;
   logic [SQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free, cnt_last;

   localparam logic [SQ_CNT_W-1:0] SQ_LAST = SQ_CNT_W'(SQ_STEPS - 1);

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign cnt_last  = cnt_ff == SQ_LAST;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_MUL1;
         ST_MUL1: state_in = status.blank ? ST_OUT : ST_MUL2;
         ST_MUL2: state_in = status.aim ? ST_A1 : ST_F1;
         ST_F1:   state_in = ST_F2;
         ST_F2:   state_in = ST_F3;
         ST_F3:   state_in = ST_F4;
         ST_F4:   state_in = ST_OUT;
         ST_A1:   state_in = ST_SQ1;
         ST_SQ1:  if (cnt_last) state_in = ST_MID;
         ST_MID:  state_in = ST_SQ2;
         ST_SQ2:  if (cnt_last) state_in = ST_AWB;
         ST_AWB:  state_in = ST_OUT;
         ST_OUT:  if (slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      cnt_in    = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_MUL1: cmd.op = OP_MUL1;
         ST_MUL2: cmd.op = OP_MUL2;
         ST_F1:   cmd.op = OP_F1;
         ST_F2:   cmd.op = OP_F2;
         ST_F3:   cmd.op = OP_F3;
         ST_F4:   cmd.op = OP_F4;
         ST_A1:   cmd.op = OP_A1;
         ST_SQ1, ST_SQ2: begin
            cmd.op = OP_SQRT;
            cnt_in = cnt_last ? '0 : cnt_ff + 1'b1;
         end
         ST_MID:  cmd.op = OP_SQ2LOAD;
         ST_AWB:  cmd.op = OP_AWB;
         ST_OUT:  if (slot_free) cmd.op = OP_OUT;
         default: cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == OP_OUT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_MUL1)
      else $error("accepted transaction did not start");

   a_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT) |=> rsp_valid_ff)
      else $error("result not presented");

   a_sqrt_pass_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ1 && cnt_ff == SQ_LAST) |=> (state_ff == ST_MID && cnt_ff == '0))
      else $error("root pass length wrong");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT) |-> slot_free)
      else $error("result overwritten before taken");

endmodule

@@ bench/mouse_to_analog_stick_core_tb.sv @@
// Self-checking testbench for mouse_to_analog_stick_core: random and directed
// mouse transactions checked against a bit-accurate predictor of the pads.
// Depends on mta_pkg, mta_chan_if and the core RTL.
`timescale 1ns / 1ps

module mouse_to_analog_stick_core_tb;
   import mta_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int SHOW_MAX   = 10;

   typedef struct {
      logic [7:0] sx;
      logic [7:0] sy;
      logic       sv;
   } stick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   mta_req_if req_if();
   mta_rsp_if rsp_if();

   mouse_to_analog_stick_core dut (
      .clock(clock), .reset(reset),
      .req_chan(req_if.sink), .rsp_chan(rsp_if.source),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // predictor state
   longint unsigned cfg[8];
   longint raw_x[PAD_COUNT], raw_y[PAD_COUNT];
   longint pos_x[PAD_COUNT], pos_y[PAD_COUNT];
   longint aimp_x[PAD_COUNT], aimp_y[PAD_COUNT];
   bit     aim_lat[PAD_COUNT];
   bit     pad_aim[PAD_COUNT];

   stick_type stick_q[$];
   int     err_count = 0;
   int     sent_count = 0;
   int     got_count = 0;
   int     idle_cycles = 0;
   int     stall_left = 0;
   bit     gaps_on = 1'b1;

   function automatic longint round_shift(longint v, int s);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 <<< (s - 1))) >>> s;
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint fourth_root_curve(longint a);
      longint unsigned m;
      if (a == 0) return 0;
      m = (a < 0) ? -a : a;
      m = int_sqrt(int_sqrt(m * (64'd13056 * 64'd13056 * 64'd13056)));
      return (a < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint slew_axis(ref longint raw, input longint pos,
                                        input longint tgt, input longint step);
      longint r, ch;
      r = round_shift(raw * longint'(cfg[REG_A_DECAY]), 8) + tgt;
      r = clip(r, -longint'(cfg[REG_LIMIT]), longint'(cfg[REG_LIMIT]));
      raw = r;
      if (r > -DEADZONE && r < DEADZONE) begin
         pos = round_shift(pos * longint'(cfg[REG_R_DECAY]), 8);
         if (pos > -DEADZONE && pos < DEADZONE) pos = 0;
      end else begin
         ch = round_shift((r - pos) * longint'(cfg[REG_ATTACK]), 8);
         pos = pos + clip(ch, -step, step);
      end
      return clip(pos, -32768, 32767);
   endfunction

   function automatic logic [7:0] stick_byte(longint pos);
      return 8'(clip(round_shift(128 * ONE_Q8 + pos, 8), 0, 255));
   endfunction

   function automatic void clear_pad(int p);
      raw_x[p] = 0; raw_y[p] = 0; pos_x[p] = 0; pos_y[p] = 0;
      aimp_x[p] = 0; aimp_y[p] = 0;
   endfunction

   function automatic stick_type predict_stick(int p, longint dx, longint dy,
                                               longint unsigned fov, bit cam, bit aim);
      stick_type s;
      longint f, tx, ty;
      s.sx = 8'd128; s.sy = 8'd128; s.sv = 1'b0;
      if (cfg[REG_ENABLE] == 0 || !cam) begin
         clear_pad(p);
         aim_lat[p] = 1'b0;
         return s;
      end
      if (aim != aim_lat[p]) begin
         clear_pad(p);
         aim_lat[p] = aim;
      end
      f = ONE_Q8;
      if (fov > FOV_MIN_Q8) f = clip(longint'(fov / 60), FOV_F_MIN, ONE_Q8);
      if (aim) begin
         aimp_x[p] = clip(aimp_x[p] + round_shift(dx * f, 8), -AIM_LIMIT, AIM_LIMIT);
         aimp_y[p] = clip(aimp_y[p] + round_shift(-dy * f, 8), -AIM_LIMIT, AIM_LIMIT);
         pos_x[p] = fourth_root_curve(aimp_x[p]);
         pos_y[p] = fourth_root_curve(aimp_y[p]);
      end else begin
         tx = round_shift(dx * longint'(cfg[REG_SCALE]) * f, 16);
         ty = round_shift(-dy * longint'(cfg[REG_SCALE]) * f, 16);
         pos_x[p] = slew_axis(raw_x[p], pos_x[p], tx, longint'(cfg[REG_STEP_X]));
         pos_y[p] = slew_axis(raw_y[p], pos_y[p], ty, longint'(cfg[REG_STEP_Y]));
      end
      s.sx = stick_byte(pos_x[p]);
      s.sy = stick_byte(pos_y[p]);
      s.sv = 1'b1;
      return s;
   endfunction

   task automatic idle_burst();
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // one mouse transaction; valid stays high into the next call
   task automatic send_move(int p, logic signed [19:0] dx, logic signed [19:0] dy,
                            logic [15:0] fov, bit cam, bit aim);
      idle_burst();
      req_if.valid         <= 1'b1;
      req_if.pad_index     <= 2'(p);
      req_if.delta_x       <= dx;
      req_if.delta_y       <= dy;
      req_if.view_fov      <= fov;
      req_if.camera_active <= cam;
      req_if.aim_active    <= aim;
      do @(posedge clock); while (!req_if.ready);
      stick_q.push_back(predict_stick(p, longint'(dx), longint'(dy), fov, cam, aim));
      sent_count++;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (stick_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [15:0] val);
      static int w[8] = '{1, 16, 15, 15, 15, 9, 9, 9};
      drain();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg[idx] = val & ((64'd1 << w[idx]) - 1);
   endtask

   function automatic logic signed [19:0] rand_delta();
      case ($urandom_range(0, 9))
         0: return 20'($urandom);
         1: return -20'sd524288;
         2: return 20'sd524287;
         3: return 20'sd0;
         default: return $urandom_range(0, 1) ? 20'($urandom_range(0, 3000))
                                              : -20'($urandom_range(0, 3000));
      endcase
   endfunction

   function automatic logic [15:0] rand_fov();
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 800));
         default: return 16'($urandom_range(20 * 256, 110 * 256));
      endcase
   endfunction

   task automatic random_moves(int n);
      int p;
      repeat (n) begin
         p = $urandom_range(0, PAD_COUNT - 1);
         if ($urandom_range(0, 15) == 0) pad_aim[p] = ~pad_aim[p];
         send_move(p, rand_delta(), rand_delta(), rand_fov(),
                   $urandom_range(0, 19) != 0, pad_aim[p]);
      end
   endtask

   task automatic test_directed();
      send_move(0, 20'sd524287, -20'sd524288, 16'd0, 1, 0);
      send_move(0, -20'sd524288, 20'sd524287, 16'hFFFF, 1, 0);
      send_move(0, 20'sd0, 20'sd0, 16'd768, 1, 0);
      send_move(0, 20'sd0, 20'sd0, 16'd768, 1, 0);
      send_move(1, 20'sd100, 20'sd100, 16'd769, 1, 0);
      send_move(1, 20'sd100, -20'sd100, 16'd179, 1, 0);
      send_move(1, 20'sd256, 20'sd256, 16'd15360, 1, 0);
      send_move(1, 20'sd256, 20'sd256, 16'd15360, 0, 0);   // camera off clears
      send_move(2, 20'sd524287, 20'sd524287, 16'd0, 1, 1);  // into aim: clear
      send_move(2, 20'sd524287, -20'sd524288, 16'd0, 1, 1); // aim clamp
      send_move(2, -20'sd300, 20'sd1, 16'd23040, 1, 1);
      send_move(2, 20'sd5, 20'sd5, 16'd23040, 1, 0);        // back to free-look
      send_move(3, 20'sd64, 20'sd64, 16'd0, 1, 1);
      send_move(3, -20'sd1, 20'sd1, 16'd0, 1, 1);
      send_move(3, 20'sd0, 20'sd0, 16'd0, 1, 1);
      send_move(3, 20'sd0, 20'sd0, 16'd0, 0, 1);
      drain();   // hold off until every result is back
      write_reg(REG_ENABLE, 16'd0);
      send_move(0, 20'sd999, 20'sd999, 16'd0, 1, 0);
      send_move(2, 20'sd999, 20'sd999, 16'd0, 1, 1);
      write_reg(REG_ENABLE, 16'd1);
      send_move(0, 20'sd999, 20'sd999, 16'd0, 1, 0);
   endtask

   task automatic test_config_extremes();
      write_reg(REG_SCALE, 16'hFFFF);
      write_reg(REG_LIMIT, 16'h7FFF);
      write_reg(REG_STEP_X, 16'h7FFF);
      write_reg(REG_STEP_Y, 16'd0);
      write_reg(REG_ATTACK, 16'd256);
      write_reg(REG_A_DECAY, 16'd256);
      write_reg(REG_R_DECAY, 16'd0);
      random_moves(80);
      write_reg(REG_SCALE, 16'd0);
      write_reg(REG_LIMIT, 16'd0);
      write_reg(REG_STEP_X, 16'd0);
      write_reg(REG_STEP_Y, 16'h7FFF);
      write_reg(REG_ATTACK, 16'd0);
      write_reg(REG_A_DECAY, 16'd0);
      write_reg(REG_R_DECAY, 16'd256);
      random_moves(60);
      write_reg(REG_SCALE, 16'hFFFF);   // full-range values; attack and limit have upper bits masked
      write_reg(REG_ATTACK, 16'hFFFF);
      write_reg(REG_A_DECAY, 16'd511);
      write_reg(REG_R_DECAY, 16'd511);
      write_reg(REG_LIMIT, 16'hFFFF);
      random_moves(40);
      write_reg(REG_ENABLE, 16'd0);
      random_moves(20);
   endtask

   task automatic test_random_settings();
      write_reg(REG_ENABLE, 16'd1);
      repeat (3) begin
         write_reg(REG_SCALE, 16'($urandom_range(256, 4096)));
         write_reg(REG_LIMIT, 16'($urandom_range(1024, 32767)));
         write_reg(REG_STEP_X, 16'($urandom_range(64, 8000)));
         write_reg(REG_STEP_Y, 16'($urandom_range(64, 8000)));
         write_reg(REG_ATTACK, 16'($urandom_range(1, 256)));
         write_reg(REG_A_DECAY, 16'($urandom_range(100, 256)));
         write_reg(REG_R_DECAY, 16'($urandom_range(50, 256)));
         random_moves(60);
      end
   endtask

   task automatic test_defaults_no_gaps();
      write_reg(REG_SCALE, 16'd2560);
      write_reg(REG_LIMIT, 16'd14336);
      write_reg(REG_STEP_X, 16'd3072);
      write_reg(REG_STEP_Y, 16'd2816);
      write_reg(REG_ATTACK, 16'd38);
      write_reg(REG_A_DECAY, 16'd210);
      write_reg(REG_R_DECAY, 16'd141);
      gaps_on = 1'b0;
      random_moves(100);
   endtask

   // result side: stalls ready in bursts while gaps are on, checks each transaction
   always @(posedge clock) begin
      stick_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else begin
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 9);
         end else begin
            rsp_if.ready <= 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got_count++;
            if (stick_q.size() == 0) begin
               err_count++;
               if (err_count <= SHOW_MAX)
                  $display("unexpected stick result x=%0d y=%0d v=%0b",
                           rsp_if.stick_x, rsp_if.stick_y, rsp_if.stick_valid);
            end else begin
               want = stick_q.pop_front();
               if (rsp_if.stick_x !== want.sx || rsp_if.stick_y !== want.sy ||
                   rsp_if.stick_valid !== want.sv) begin
                  err_count++;
                  if (err_count <= SHOW_MAX)
                     $display("stick mismatch #%0d: exp x=%0d y=%0d v=%0b got x=%0d y=%0d v=%0b",
                              got_count, want.sx, want.sy, want.sv,
                              rsp_if.stick_x, rsp_if.stick_y, rsp_if.stick_valid);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("mouse_to_analog_stick_core_tb: done, errors");
         $finish;
      end
   end

   initial begin
      static longint unsigned rst_vals[8] = '{1, 2560, 14336, 3072, 2816, 38, 210, 141};
      for (int i = 0; i < 8; i++) cfg[i] = rst_vals[i];
      for (int p = 0; p < PAD_COUNT; p++) begin
         clear_pad(p);
         aim_lat[p] = 1'b0;
         pad_aim[p] = 1'b0;
      end
      req_if.valid = 1'b0;
      req_if.pad_index = '0;
      req_if.delta_x = '0;
      req_if.delta_y = '0;
      req_if.view_fov = '0;
      req_if.camera_active = 1'b0;
      req_if.aim_active = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      random_moves(60);
      test_config_extremes();
      test_random_settings();
      test_defaults_no_gaps();
      drain();
      repeat (100) @(posedge clock);
      if (stick_q.size() != 0) err_count += stick_q.size();

      $display("covered %0d transactions over default, extreme and random register settings,",
               sent_count);
      $display("with free-look, aim, cleared pads and mouse mode off; %0d results checked",
               got_count);
      if (err_count == 0)
         $display("mouse_to_analog_stick_core_tb: done, clean");
      else
         $display("mouse_to_analog_stick_core_tb: done, errors");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/mta_pkg.sv
rtl/core/mta_chan_if.sv
rtl/core/mta_datapath.sv
rtl/core/mta_ctrl.sv
rtl/core/mouse_to_analog_stick_core.sv
bench/mouse_to_analog_stick_core_tb.sv
